FILE: rtl/eg_pkg.sv
package eg_pkg;
  localparam int WORD_BITS = 31;
  localparam int CNT_BITS = 6;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_ENC = 2'd0;
  localparam opcode_t OP_DEC = 2'd1;
  localparam opcode_t OP_KEY = 2'd2;
  localparam opcode_t OP_RSVD = 2'd3;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_GENERATOR = 2'd1;
  localparam logic [1:0] REG_PUBLIC = 2'd2;
  localparam logic [1:0] REG_PRIVATE = 2'd3;

  localparam word_t RST_MODULUS = word_t'(7481);
  localparam word_t RST_GENERATOR = word_t'(2);
  localparam word_t RST_PUBLIC = word_t'(786);
  localparam word_t RST_PRIVATE = word_t'(39);

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t p;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
  } mm_rsp_t;
endpackage

FILE: rtl/eg_if.sv
interface eg_in_if;
  logic              valid;
  logic              ready;
  eg_pkg::opcode_t   opcode;
  eg_pkg::word_t     message;
  eg_pkg::word_t     nonce;
  eg_pkg::word_t     cipher_first;
  eg_pkg::word_t     cipher_second;
  modport source (output valid, opcode, message, nonce, cipher_first, cipher_second,
                  input ready);
  modport sink (input valid, opcode, message, nonce, cipher_first, cipher_second,
                output ready);
endinterface

interface eg_out_if;
  logic          valid;
  logic          ready;
  eg_pkg::word_t first_value;
  eg_pkg::word_t second_value;
  modport source (output valid, first_value, second_value, input ready);
  modport sink (input valid, first_value, second_value, output ready);
endinterface

interface eg_cfg_if;
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  eg_pkg::word_t data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/eg_modmul.sv
// Bit-serial interleaved modular multiply: one multiplier bit per cycle, MSB first.
module eg_modmul (
  input  logic             clk,
  input  logic             rst,
  input  eg_pkg::mm_req_t  req,
  output eg_pkg::mm_rsp_t  rsp
);
  localparam int W = eg_pkg::WORD_BITS;
  logic [W:0] acc;
  logic [W-1:0] mb;
  eg_pkg::word_t ma, mp;
  logic [eg_pkg::CNT_BITS-1:0] cnt;
  logic busy, done;
  logic [W+1:0] dbl, t1, t2, add;

  always_comb begin
    dbl = {acc, 1'b0};
    t1 = (dbl >= {2'b0, mp}) ? dbl - {2'b0, mp} : dbl;
    add = t1 + (mb[W-1] ? {2'b0, ma} : '0);
    t2 = (add >= {2'b0, mp}) ? add - {2'b0, mp} : add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= eg_pkg::CNT_BITS'(W);
        acc <= '0;
        ma <= req.a;
        mb <= req.b;
        mp <= req.p;
      end else if (busy) begin
        acc <= t2[W:0];
        mb <= {mb[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == eg_pkg::CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res = acc[W-1:0];
endmodule

FILE: rtl/eg_seq.sv
module eg_seq (
  input  logic            clk,
  input  logic            rst,
  eg_in_if.sink           in_ch,
  eg_out_if.source        out_ch,
  input  eg_pkg::word_t   modulus,
  input  eg_pkg::word_t   generator,
  input  eg_pkg::word_t   public_key,
  input  eg_pkg::word_t   private_key,
  output eg_pkg::mm_req_t req,
  input  eg_pkg::mm_rsp_t rsp
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC = 3'd1;
  localparam logic [2:0] S_SQ = 3'd2;
  localparam logic [2:0] S_FIN = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_RED = 3'd5;

  logic [2:0] state;
  logic wait_mm;
  logic mm_start;
  logic [1:0] phase;
  eg_pkg::opcode_t op;
  eg_pkg::word_t p, acc, sq, ex, m, f, s, base2;
  eg_pkg::word_t mm_a, mm_b;
  logic [eg_pkg::CNT_BITS-1:0] bitn;
  eg_pkg::word_t pm1;
  eg_pkg::word_t in_nonce_hold;

  assign pm1 = modulus - 1'b1;
  assign in_ch.ready = (state == S_IDLE);

  // phase 0: first power, phase 1: second power (encrypt), then final multiply (not for keygen)
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wait_mm <= 1'b0;
      mm_start <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid) begin
          op <= in_ch.opcode;
          p <= modulus;
          m <= in_ch.message;
          s <= '0;
          f <= '0;
          phase <= 2'd0;
          bitn <= '0;
          acc <= eg_pkg::word_t'(modulus != eg_pkg::word_t'(1));
          if (modulus == '0 || in_ch.opcode == eg_pkg::OP_RSVD) begin
            state <= S_OUT;
            out_ch.valid <= 1'b1;
          end else begin
            case (in_ch.opcode)
              eg_pkg::OP_ENC: begin
                sq <= generator; ex <= in_ch.nonce; base2 <= public_key;
              end
              eg_pkg::OP_DEC: begin
                sq <= in_ch.cipher_first;
                ex <= (private_key < pm1) ? pm1 - private_key : '0;
                m <= in_ch.cipher_second;
              end
              default: begin
                sq <= generator; ex <= private_key;
              end
            endcase
            state <= S_RED;
            mm_start <= 1'b1;
          end
        end
        S_RED: if (!mm_start && rsp.done) begin
          sq <= rsp.res;
          state <= S_ACC;
        end
        S_ACC: begin
          if (!wait_mm) begin
            if (bitn == eg_pkg::CNT_BITS'(eg_pkg::WORD_BITS)) begin
              state <= S_FIN;
            end else if (ex[0]) begin
              mm_start <= 1'b1; wait_mm <= 1'b1;
            end else begin
              state <= S_SQ;
            end
          end else if (!mm_start && rsp.done) begin
            acc <= rsp.res; wait_mm <= 1'b0; state <= S_SQ;
          end
        end
        S_SQ: begin
          if (!wait_mm) begin
            mm_start <= 1'b1; wait_mm <= 1'b1;
          end else if (!mm_start && rsp.done) begin
            sq <= rsp.res; wait_mm <= 1'b0;
            ex <= {1'b0, ex[eg_pkg::WORD_BITS-1:1]};
            bitn <= bitn + 1'b1;
            state <= S_ACC;
          end
        end
        S_FIN: begin
          if (!wait_mm) begin
            if (op == eg_pkg::OP_KEY) begin
              f <= acc; state <= S_OUT; out_ch.valid <= 1'b1;
            end else if (op == eg_pkg::OP_ENC && phase == 2'd0) begin
              f <= acc; phase <= 2'd1; sq <= base2; ex <= in_nonce_hold;
              acc <= eg_pkg::word_t'(p != eg_pkg::word_t'(1));
              bitn <= '0; mm_start <= 1'b1; state <= S_RED;
            end else begin
              mm_start <= 1'b1; wait_mm <= 1'b1;
            end
          end else if (!mm_start && rsp.done) begin
            wait_mm <= 1'b0;
            if (op == eg_pkg::OP_ENC) s <= rsp.res; else f <= rsp.res;
            state <= S_OUT; out_ch.valid <= 1'b1;
          end
        end
        S_OUT: if (out_ch.ready) begin
          out_ch.valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) in_nonce_hold <= in_ch.nonce;
  end

  // operand routing; a must be below p, b may be any word (reduces m, c2, bases)
  always_comb begin
    case (state)
      S_RED: begin mm_a = eg_pkg::word_t'(1); mm_b = sq; end
      S_ACC: begin mm_a = acc; mm_b = sq; end
      S_SQ: begin mm_a = sq; mm_b = sq; end
      S_FIN: begin mm_a = acc; mm_b = m; end
      default: begin mm_a = eg_pkg::word_t'(1); mm_b = sq; end
    endcase
  end

  assign req = '{start: mm_start, a: mm_a, b: mm_b, p: p};

  assign out_ch.first_value = f;
  assign out_ch.second_value = s;
endmodule

FILE: rtl/elgamal_encrypt_decrypt_core.sv
// channel | role  | payload
// in_ch   | sink  | opcode, message, nonce, cipher_first, cipher_second
// out_ch  | source| first_value, second_value
// cfg_ch  | sink  | index, data (always ready)
// Each modular multiply runs 31 bit steps.
// A zero exponent still costs 31 squarings per power.
// One item at a time; in_ch.ready is high only when idle.
// Reset (rst, synchronous) restores default key registers.
// Result holds in an output register until out_ch.ready; a stalled result blocks input.
module elgamal_encrypt_decrypt_core (
  input logic clk,
  input logic rst,
  eg_in_if.sink in_ch,
  eg_out_if.source out_ch,
  eg_cfg_if.sink cfg_ch
);
  eg_pkg::word_t modulus, generator, public_key, private_key;
  eg_pkg::mm_req_t req;
  eg_pkg::mm_rsp_t rsp;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= eg_pkg::RST_MODULUS;
      generator <= eg_pkg::RST_GENERATOR;
      public_key <= eg_pkg::RST_PUBLIC;
      private_key <= eg_pkg::RST_PRIVATE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        eg_pkg::REG_MODULUS: modulus <= cfg_ch.data;
        eg_pkg::REG_GENERATOR: generator <= cfg_ch.data;
        eg_pkg::REG_PUBLIC: public_key <= cfg_ch.data;
        eg_pkg::REG_PRIVATE: private_key <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  eg_seq u_seq (.clk, .rst, .in_ch, .out_ch, .modulus, .generator, .public_key,
                .private_key, .req, .rsp);
  eg_modmul u_mm (.clk, .rst, .req, .rsp);
endmodule

FILE: rtl/eg_checker.sv
module eg_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input eg_pkg::word_t first_value,
  input eg_pkg::word_t second_value
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("ready while result pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(first_value)
      && $stable(second_value)))
    else $error("result dropped");
endmodule

bind elgamal_encrypt_decrypt_core eg_checker u_chk (.clk, .rst,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .first_value(out_ch.first_value),
  .second_value(out_ch.second_value));
